// ----- hdl/plist_pkg.sv -----
// Package: types, constants and control codes for the positional list core.
package plist_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int VAL_W    = 32;

  localparam logic [2:0] CMD_INS_TAIL = 3'd0;
  localparam logic [2:0] CMD_INS_HEAD = 3'd1;
  localparam logic [2:0] CMD_INS_AT   = 3'd2;
  localparam logic [2:0] CMD_DEL_AT   = 3'd3;
  localparam logic [2:0] CMD_DEL_HEAD = 3'd4;
  localparam logic [2:0] CMD_READ     = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [4:0]              position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] entry_value;
    logic [3:0]              entry_index;
    logic [CNT_W-1:0]        length;
    logic                    last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UP,
    S_DN,
    S_READ
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SET_UP,
    DP_SET_DN,
    DP_SET_RD,
    DP_MOVE_UP,
    DP_MOVE_DN,
    DP_INS_DONE,
    DP_DEL_DONE,
    DP_EMIT_ERR,
    DP_EMIT_RD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_ctl_t;

  typedef struct packed {
    logic out_free;
    logic err;
    logic is_ins;
    logic is_del;
    logic up_more;
    logic dn_more;
    logic rd_last;
  } dp_stat_t;

endpackage

// ----- hdl/positional_list_insert_delete_core.sv -----
// Top level: bounded positional list core, controller plus datapath.
//
//   channel  valid      ready      payload
//   request  req_valid  req_ready  req (plist_pkg::req_t)
//   response rsp_valid  rsp_ready  rsp (plist_pkg::rsp_t)
//
// Error commands are answered from decode; insert shifts the cells at and above
// position up one, delete shifts those above it down one; a read emits each entry.
// The shift loop moves one cell per cycle through the single entry read port.
// Reset clears the length and response valid flag; entry storage is not cleared.
// A stalled response holds the next result back; a new request transfer is
// taken while the last result of the previous one is still waiting.
module positional_list_insert_delete_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  plist_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output plist_pkg::rsp_t   rsp
);

  plist_pkg::dp_ctl_t  ctl;
  plist_pkg::dp_stat_t stat;

  plist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  plist_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_ready (rsp_ready),
    .ctl       (ctl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

// ----- hdl/plist_dp.sv -----
// Datapath: entry storage, count, shift index, command latch and response register.
module plist_dp (
  input  logic              clk,
  input  logic              rst,
  input  plist_pkg::req_t   req,
  input  logic              rsp_ready,
  input  plist_pkg::dp_ctl_t ctl,
  output plist_pkg::dp_stat_t stat,
  output logic              rsp_valid,
  output plist_pkg::rsp_t   rsp
);

  logic signed [plist_pkg::VAL_W-1:0] entries [plist_pkg::CAPACITY];
  logic [plist_pkg::CNT_W-1:0]        count;
  logic [plist_pkg::CNT_W-1:0]        count_next;
  logic [plist_pkg::IDX_W-1:0]        idx;
  logic [2:0]                         cmd;
  logic [plist_pkg::CNT_W-1:0]        pos;
  logic [plist_pkg::CNT_W-1:0]        pos_next;
  logic signed [plist_pkg::VAL_W-1:0] value;
  logic [plist_pkg::IDX_W-1:0]        rd_addr;
  logic signed [plist_pkg::VAL_W-1:0] rd_data;
  logic [plist_pkg::CNT_W-1:0]        idx_ext;
  logic [1:0]                         err_code;
  logic                               err;
  logic                               is_ins;
  logic                               is_del;
  logic                               out_free;

  assign idx_ext  = plist_pkg::CNT_W'(idx);
  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    case (req.cmd)
      plist_pkg::CMD_INS_TAIL: pos_next = count;
      plist_pkg::CMD_INS_AT,
      plist_pkg::CMD_DEL_AT:   pos_next = req.position;
      default:                 pos_next = '0;
    endcase
  end

  always_comb begin
    is_ins   = 1'b0;
    is_del   = 1'b0;
    err      = 1'b0;
    err_code = plist_pkg::ST_OK;
    case (cmd)
      plist_pkg::CMD_INS_TAIL,
      plist_pkg::CMD_INS_HEAD,
      plist_pkg::CMD_INS_AT: begin
        is_ins = 1'b1;
        if (count >= plist_pkg::CNT_W'(plist_pkg::CAPACITY)) begin
          err      = 1'b1;
          err_code = plist_pkg::ST_FULL;
        end else if (pos > count) begin
          err      = 1'b1;
          err_code = plist_pkg::ST_BADPOS;
        end
      end
      plist_pkg::CMD_DEL_AT,
      plist_pkg::CMD_DEL_HEAD: begin
        is_del = 1'b1;
        if (count == '0) begin
          err      = 1'b1;
          err_code = plist_pkg::ST_EMPTY;
        end else if (pos >= count) begin
          err      = 1'b1;
          err_code = plist_pkg::ST_BADPOS;
        end
      end
      plist_pkg::CMD_READ: begin
        if (count == '0) begin
          err      = 1'b1;
          err_code = plist_pkg::ST_EMPTY;
        end
      end
      default: begin
        err      = 1'b1;
        err_code = plist_pkg::ST_BADPOS;
      end
    endcase
  end

  // prefetch address: the entry needed in the following cycle
  always_comb begin
    case (ctl.op)
      plist_pkg::DP_SET_UP:  rd_addr = count[plist_pkg::IDX_W-1:0] - 1'b1;
      plist_pkg::DP_SET_DN:  rd_addr = pos[plist_pkg::IDX_W-1:0] + 1'b1;
      plist_pkg::DP_SET_RD:  rd_addr = '0;
      plist_pkg::DP_MOVE_UP: rd_addr = idx - 2'd2;
      plist_pkg::DP_MOVE_DN: rd_addr = idx + 2'd2;
      plist_pkg::DP_EMIT_RD: rd_addr = idx + 1'b1;
      default:               rd_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= entries[rd_addr];
  end

  always_comb begin
    stat.out_free = out_free;
    stat.err      = err;
    stat.is_ins   = is_ins;
    stat.is_del   = is_del;
    stat.up_more  = idx_ext > pos;
    stat.dn_more  = (idx_ext + 1'b1) < count;
    stat.rd_last  = (idx_ext + 1'b1) == count;
  end

  always_comb begin
    case (ctl.op)
      plist_pkg::DP_INS_DONE: count_next = count + 1'b1;
      plist_pkg::DP_DEL_DONE: count_next = count - 1'b1;
      default:                count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      plist_pkg::DP_LOAD: begin
        cmd   <= req.cmd;
        pos   <= pos_next;
        value <= req.value;
      end
      plist_pkg::DP_SET_UP: idx <= count[plist_pkg::IDX_W-1:0];
      plist_pkg::DP_SET_DN: idx <= pos[plist_pkg::IDX_W-1:0];
      plist_pkg::DP_SET_RD: idx <= '0;
      plist_pkg::DP_MOVE_UP: begin
        entries[idx] <= rd_data;
        idx          <= idx - 1'b1;
      end
      plist_pkg::DP_MOVE_DN: begin
        entries[idx] <= rd_data;
        idx          <= idx + 1'b1;
      end
      plist_pkg::DP_INS_DONE: entries[pos[plist_pkg::IDX_W-1:0]] <= value;
      plist_pkg::DP_EMIT_RD:  idx <= idx + 1'b1;
      default: ;
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      case (ctl.op)
        plist_pkg::DP_INS_DONE,
        plist_pkg::DP_DEL_DONE,
        plist_pkg::DP_EMIT_ERR,
        plist_pkg::DP_EMIT_RD: rsp_valid <= 1'b1;
        default: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      plist_pkg::DP_INS_DONE,
      plist_pkg::DP_DEL_DONE: begin
        rsp.status      <= plist_pkg::ST_OK;
        rsp.entry_value <= '0;
        rsp.entry_index <= '0;
        rsp.length      <= count_next;
        rsp.last        <= 1'b1;
      end
      plist_pkg::DP_EMIT_ERR: begin
        rsp.status      <= err_code;
        rsp.entry_value <= '0;
        rsp.entry_index <= '0;
        rsp.length      <= count;
        rsp.last        <= 1'b1;
      end
      plist_pkg::DP_EMIT_RD: begin
        rsp.status      <= plist_pkg::ST_OK;
        rsp.entry_value <= rd_data;
        rsp.entry_index <= 4'(idx);
        rsp.length      <= count;
        rsp.last        <= stat.rd_last;
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/plist_ctrl.sv -----
// Controller: sequences accept, decode, one-cell-per-cycle shifts and read streaming.
module plist_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  plist_pkg::dp_stat_t stat,
  output plist_pkg::dp_ctl_t  ctl
);

  plist_pkg::state_t state;
  plist_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plist_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.op     = plist_pkg::DP_NOP;
    req_ready  = 1'b0;
    case (state)
      plist_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.op     = plist_pkg::DP_LOAD;
          state_next = plist_pkg::S_DECODE;
        end
      end
      plist_pkg::S_DECODE: begin
        if (stat.err) begin
          if (stat.out_free) begin
            ctl.op     = plist_pkg::DP_EMIT_ERR;
            state_next = plist_pkg::S_IDLE;
          end
        end else if (stat.is_ins) begin
          ctl.op     = plist_pkg::DP_SET_UP;
          state_next = plist_pkg::S_UP;
        end else if (stat.is_del) begin
          ctl.op     = plist_pkg::DP_SET_DN;
          state_next = plist_pkg::S_DN;
        end else begin
          ctl.op     = plist_pkg::DP_SET_RD;
          state_next = plist_pkg::S_READ;
        end
      end
      plist_pkg::S_UP: begin
        if (stat.up_more) begin
          ctl.op = plist_pkg::DP_MOVE_UP;
        end else if (stat.out_free) begin
          ctl.op     = plist_pkg::DP_INS_DONE;
          state_next = plist_pkg::S_IDLE;
        end
      end
      plist_pkg::S_DN: begin
        if (stat.dn_more) begin
          ctl.op = plist_pkg::DP_MOVE_DN;
        end else if (stat.out_free) begin
          ctl.op     = plist_pkg::DP_DEL_DONE;
          state_next = plist_pkg::S_IDLE;
        end
      end
      plist_pkg::S_READ: begin
        if (stat.out_free) begin
          ctl.op = plist_pkg::DP_EMIT_RD;
          if (stat.rd_last) begin
            state_next = plist_pkg::S_IDLE;
          end
        end
      end
      default: state_next = plist_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- hdl/plist_chk.sv -----
// Checker: port-level properties of the positional list core, bound to the top level.
module plist_chk (
  input logic            clk,
  input logic            rst,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input plist_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == plist_pkg::ST_FULL
      |-> rsp.length == plist_pkg::CNT_W'(plist_pkg::CAPACITY))
    else $error("full status with short length");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == plist_pkg::ST_EMPTY |-> rsp.length == '0)
    else $error("empty status with nonzero length");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != plist_pkg::ST_OK |-> rsp.last && rsp.entry_value == '0)
    else $error("error result not single or carries data");

  a_rd_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last
      |-> (plist_pkg::CNT_W'(rsp.entry_index) + 1'b1) < rsp.length)
    else $error("read index beyond length");

endmodule

bind positional_list_insert_delete_core plist_chk u_plist_chk (.*);

// ----- sim/positional_list_insert_delete_core_tb.sv -----
// Testbench: positional list core checked transfer by transfer against a behavioral list model.
`timescale 1ns / 1ps

module positional_list_insert_delete_core_tb;

  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
  localparam logic signed [plist_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [plist_pkg::VAL_W-1:0] VAL_MIN = 32'sh80000000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  plist_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  plist_pkg::rsp_t rsp;

  plist_pkg::req_t cmd_queue[$];
  plist_pkg::rsp_t expected_rsps[$];

  logic signed [plist_pkg::VAL_W-1:0] list_vals[plist_pkg::CAPACITY];
  int list_len = 0;

  int gen_len = 0;
  bit growing = 1'b1;
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int errors = 0;
  int stall_cycles = 0;

  positional_list_insert_delete_core dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void push_expected(logic [1:0] st, logic signed [plist_pkg::VAL_W-1:0] v,
                                        int idx, int len, bit lst);
    plist_pkg::rsp_t r;
    r.status      = st;
    r.entry_value = v;
    r.entry_index = idx[3:0];
    r.length      = len[plist_pkg::CNT_W-1:0];
    r.last        = lst;
    expected_rsps.push_back(r);
  endfunction

  function automatic logic [1:0] list_insert(int pos, logic signed [plist_pkg::VAL_W-1:0] v);
    if (list_len >= plist_pkg::CAPACITY) return plist_pkg::ST_FULL;
    if (pos > list_len) return plist_pkg::ST_BADPOS;
    for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
    list_vals[pos] = v;
    list_len++;
    return plist_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] list_delete(int pos);
    if (list_len == 0) return plist_pkg::ST_EMPTY;
    if (pos >= list_len) return plist_pkg::ST_BADPOS;
    for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
    list_len--;
    return plist_pkg::ST_OK;
  endfunction

  function automatic void predict_list_op(plist_pkg::req_t r);
    logic [1:0] st;
    case (r.cmd)
      plist_pkg::CMD_INS_TAIL: st = list_insert(list_len, r.value);
      plist_pkg::CMD_INS_HEAD: st = list_insert(0, r.value);
      plist_pkg::CMD_INS_AT:   st = list_insert(int'(r.position), r.value);
      plist_pkg::CMD_DEL_AT:   st = list_delete(int'(r.position));
      plist_pkg::CMD_DEL_HEAD: st = list_delete(0);
      plist_pkg::CMD_READ: begin
        if (list_len == 0) begin
          push_expected(plist_pkg::ST_EMPTY, '0, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++)
            push_expected(plist_pkg::ST_OK, list_vals[i], i, list_len, i == list_len - 1);
        end
        return;
      end
      default: st = plist_pkg::ST_BADPOS;
    endcase
    push_expected(st, '0, 0, list_len, 1'b1);
  endfunction

  function automatic void check_result(plist_pkg::rsp_t got);
    plist_pkg::rsp_t want;
    if (expected_rsps.size() == 0) begin
      $error("unexpected result: %p", got);
      errors++;
      return;
    end
    want = expected_rsps.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.entry_value !== want.entry_value) begin
      $error("entry_value: expected %0d, got %0d", want.entry_value, got.entry_value);
      errors++;
    end
    if (got.entry_index !== want.entry_index) begin
      $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
      errors++;
    end
    if (got.length !== want.length) begin
      $error("length: expected %0d, got %0d", want.length, got.length);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      errors++;
    end
  endfunction

  // length tracking at generation time keeps random positions mostly in range
  function automatic void queue_item(plist_pkg::req_t r);
    cmd_queue.push_back(r);
    case (r.cmd)
      plist_pkg::CMD_INS_TAIL, plist_pkg::CMD_INS_HEAD:
        if (gen_len < plist_pkg::CAPACITY) gen_len++;
      plist_pkg::CMD_INS_AT:
        if (gen_len < plist_pkg::CAPACITY && int'(r.position) <= gen_len) gen_len++;
      plist_pkg::CMD_DEL_HEAD: if (gen_len > 0) gen_len--;
      plist_pkg::CMD_DEL_AT: if (int'(r.position) < gen_len) gen_len--;
      default: ;
    endcase
    if (gen_len == plist_pkg::CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
    if (gen_len == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
  endfunction

  function automatic plist_pkg::req_t random_item();
    plist_pkg::req_t r;
    int pick;
    case ($urandom_range(0, 19))
      0: r.value = VAL_MAX;
      1: r.value = VAL_MIN;
      2: r.value = '0;
      3: r.value = -1;
      default: r.value = $urandom;
    endcase
    r.position = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 99) < 8) begin
      r.cmd = 3'($urandom_range(0, 7));
      return r;
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.cmd = plist_pkg::CMD_READ;
    end else if (growing ? pick < 80 : pick < 35) begin
      case ($urandom_range(0, 2))
        0: r.cmd = plist_pkg::CMD_INS_TAIL;
        1: r.cmd = plist_pkg::CMD_INS_HEAD;
        default: begin
          r.cmd = plist_pkg::CMD_INS_AT;
          r.position = 5'($urandom_range(0, gen_len));
        end
      endcase
    end else if ($urandom_range(0, 1) == 0) begin
      r.cmd = plist_pkg::CMD_DEL_HEAD;
    end else begin
      r.cmd = plist_pkg::CMD_DEL_AT;
      r.position = (gen_len > 0) ? 5'($urandom_range(0, gen_len - 1)) : 5'd0;
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || req_valid || expected_rsps.size() > 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) predict_list_op(req);
      if (!req_valid || req_ready) begin
        if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req       <= cmd_queue.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) check_result(rsp);
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list corners and unused codes, then inserts, deletes and bad positions on a short list
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_READ,     5'd0,  32'sd0});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_DEL_HEAD, 5'd0,  32'sd0});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_DEL_AT,   5'd0,  32'sd0});
    queue_item(plist_pkg::req_t'{CMD_UNUSED_6,            5'd0,  32'sd0});
    queue_item(plist_pkg::req_t'{CMD_UNUSED_7,            5'd31, VAL_MAX});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_INS_AT,   5'd1,  32'sd5});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_INS_TAIL, 5'd0,  VAL_MAX});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_INS_HEAD, 5'd0,  VAL_MIN});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_INS_AT,   5'd1,  -32'sd1});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_INS_AT,   5'd3,  32'sd0});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_DEL_AT,   5'd4,  32'sd0});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_DEL_AT,   5'd31, 32'sd0});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_INS_AT,   5'd31, 32'sd7});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_READ,     5'd0,  32'sd0});
    // fill to capacity, then full-list corners
    while (gen_len < plist_pkg::CAPACITY)
      queue_item(plist_pkg::req_t'{plist_pkg::CMD_INS_TAIL, 5'd0, $urandom});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_INS_TAIL, 5'd0,  32'sd1});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_INS_AT,   5'd31, 32'sd2});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_READ,     5'd0,  32'sd0});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_DEL_AT,   5'd15, 32'sd0});
    queue_item(plist_pkg::req_t'{plist_pkg::CMD_DEL_HEAD, 5'd0,  32'sd0});
    growing = 1'b0;
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 87; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 87; end
        default: begin send_idle_pct = 16; rsp_stall_pct = 16; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) queue_item(random_item());
      wait_drained();
    end

    repeat (30) @(negedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
